@@ rtl/core/dasc_pkg.sv @@
// shared constants and types for the decimal ascii to wide integer block
package dasc_pkg;

  // result geometry
  localparam int MAX_WIDTH  = 128;
  localparam int WORD_W     = 64;
  localparam int ACC_WORDS  = (MAX_WIDTH + WORD_W - 1) / WORD_W;
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W      = $clog2(ACC_WORDS + 1);

  // input field widths
  localparam int CHAR_W     = 8;
  localparam int TWIDTH_W   = 8;

  // token queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // finished token handed from front to back
  typedef struct packed {
    logic [MAX_WIDTH-1:0] acc;
    logic                 minus;
    logic [WIDTH_W-1:0]   width;
  } token_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ rtl/core/dasc_front.sv @@
// front end: takes characters, tracks sign and digits, builds the accumulator
module dasc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dasc_pkg::CHAR_W-1:0]    in_char,
  input  logic                           in_last,
  input  logic [dasc_pkg::TWIDTH_W-1:0]  in_width,
  input  dasc_pkg::fifo_status_t         q_status,
  output logic                           q_push,
  output dasc_pkg::token_t               q_data
);
  import dasc_pkg::*;

  logic [MAX_WIDTH-1:0] acc, acc_next;
  logic                 minus_seen, minus_next;
  logic                 at_first, stopped, stopped_next;
  logic                 accept, is_digit, is_minus, is_plus, handled;
  logic [3:0]           digit;
  logic [WIDTH_W-1:0]   width_sat;

  // classify the incoming character
  always_comb begin
    is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    is_minus = (in_char == CHAR_MINUS);
    is_plus  = (in_char == CHAR_PLUS);
    handled  = at_first && (is_minus || is_plus);
    digit    = 4'(in_char - CHAR_ZERO);
  end

  // accumulate: acc*10 + digit as shift and add
  always_comb begin
    acc_next     = acc;
    stopped_next = stopped;
    minus_next   = minus_seen || (at_first && is_minus);
    if (!handled && !stopped) begin
      if (is_digit) begin
        acc_next = (acc << 3) + (acc << 1) + MAX_WIDTH'(digit);
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  // clamp the requested width
  always_comb begin
    if (32'(in_width) > MAX_WIDTH) begin
      width_sat = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_sat = WIDTH_W'(in_width);
    end
  end

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // hand the finished token to the queue, zero width gives nothing
  assign q_push       = accept && in_last && (width_sat != '0);
  assign q_data.acc   = acc_next;
  assign q_data.minus = minus_next;
  assign q_data.width = width_sat;

  // token state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      minus_seen <= 1'b0;
      at_first   <= 1'b1;
      stopped    <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        acc        <= '0;
        minus_seen <= 1'b0;
        at_first   <= 1'b1;
        stopped    <= 1'b0;
      end else begin
        acc        <= acc_next;
        minus_seen <= minus_next;
        at_first   <= 1'b0;
        stopped    <= stopped_next;
      end
    end
  end

endmodule

@@ rtl/core/dasc_fifo.sv @@
// short token queue between front and back
module dasc_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dasc_pkg::token_t        push_data,
  input  logic                    pop,
  output dasc_pkg::token_t        head,
  output dasc_pkg::fifo_status_t  status
);
  import dasc_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign status.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/dasc_back.sv @@
// back end: negates, masks and sends each token out as 64-bit words
module dasc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dasc_pkg::fifo_status_t        q_status,
  input  dasc_pkg::token_t              q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dasc_pkg::WORD_W-1:0]   out_word,
  output logic                          out_index,
  output logic                          out_last
);
  import dasc_pkg::*;

  logic [MAX_WIDTH-1:0] val, load_val, signed_val, mask;
  logic [CNT_W-1:0]     remaining, load_cnt;
  logic [WIDTH_W:0]     width_round;
  logic                 busy, index, emit, last_emit;

  // two's complement and width mask of the queued token
  always_comb begin
    signed_val = q_head.minus ? (~q_head.acc + MAX_WIDTH'(1)) : q_head.acc;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (i < 32'(q_head.width));
    end
    load_val    = signed_val & mask;
    width_round = {1'b0, q_head.width} + (WIDTH_W + 1)'(WORD_W - 1);
    load_cnt    = CNT_W'(width_round >> $clog2(WORD_W));
  end

  // word issue and queue pop
  assign emit      = busy && (!out_valid || out_ready);
  assign last_emit = emit && (remaining == CNT_W'(1));
  assign q_pop     = !q_status.empty && (!busy || last_emit);

  // word sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
      index     <= 1'b0;
    end else if (q_pop) begin
      busy      <= 1'b1;
      remaining <= load_cnt;
      index     <= 1'b0;
    end else if (emit) begin
      busy      <= !last_emit;
      remaining <= remaining - 1'b1;
      index     <= !index;
    end
  end

  // value being shifted out
  always_ff @(posedge clk) begin
    if (q_pop) begin
      val <= load_val;
    end else if (emit) begin
      val <= val >> WORD_W;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word  <= val[WORD_W-1:0];
      out_index <= index;
      out_last  <= (remaining == CNT_W'(1));
    end
  end

  // checks
  a_busy_has_words: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remaining != '0))
    else $error("busy with no words left");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (busy && (remaining != '0) && (index == 1'b0)))
    else $error("token pop did not start a word run");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (last_emit && !q_pop) |=> !busy)
    else $error("sequencer still busy after final word");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("issued word not presented");

endmodule

@@ rtl/core/decimal_ascii_to_wide_int.sv @@
// top level: signed decimal ascii token to wide two's complement integer
// a token passes through the token queue, word sequencer and output register
// throughput: one character request per cycle while the queue is not full; each
//   token gives ceil(width/64) words, one word per cycle while m_tready is high
// a two-entry token queue lets the front keep taking characters while words drain
// reset (rst, synchronous) clears token state, queue and output valid
module decimal_ascii_to_wide_int (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] character, [15:8] target_width
  input  logic        s_tlast,   // end_of_token
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] word
  output logic        m_tuser,   // [0] word_index
  output logic        m_tlast    // last_word
);
  import dasc_pkg::*;

  token_t       push_data, head;
  fifo_status_t q_status;
  logic         push, pop;

  // character front end
  dasc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata[7:0]),
    .in_last  (s_tlast),
    .in_width (s_tdata[15:8]),
    .q_status (q_status),
    .q_push   (push),
    .q_data   (push_data)
  );

  // token queue
  dasc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // word back end
  dasc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_index (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
